/* design/hsk_pkg.sv */
// hsk_pkg: record type and field widths for the heap sorter
// no dependencies; imported by heap_sort_by_key and tb_top
package hsk_pkg;

  localparam int KEY_W = 14;
  localparam int TAG_W = 16;

  // one stored record: the key in the upper bits, the tag below it
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

/* design/heap_sort_by_key.sv */
// heap_sort_by_key: batch heap sorter over key and tag records
// depends on hsk_pkg and hsk_ram
//
// Records are loaded one word per cycle while in_stall is low into a single ram of DEPTH
// entries; the word with batch_end closes the batch, and words beyond DEPTH are dropped and
// flag the whole batch as overflowed. The block then runs a max-heap sort in place in the
// ram (bottom-up build, then root-to-end swaps with sift-down, promoting only strictly
// greater children) and emits every record in ascending key order, run_last on the final
// one. Each level of a sift-down reads both children through the two ram read ports, then
// compares and writes back; each result passes through the output register. No input word
// is taken from batch end until the last result is in the output register.
module heap_sort_by_key
  import hsk_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] discount_key,
  input  logic [TAG_W-1:0] item_tag,
  input  logic             batch_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] sorted_key,
  output logic [TAG_W-1:0] sorted_tag,
  output logic             run_last,
  output logic             overflowed
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_LOAD,
    S_BUILD_NEXT,
    S_SIFT_HOLD,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_EX_NEXT,
    S_EX_WR,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic          ovf;
  logic [CW-1:0] count;
  logic [CW-1:0] j;
  logic [CW-1:0] size;
  logic [CW-1:0] k;
  logic [AW-1:0] node;
  logic          build_phase;
  rec_t          hold;

  // ram controls
  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;
  logic          re_a;
  logic [AW-1:0] raddr_a;
  rec_t          rdata_a;
  logic          re_b;
  logic [AW-1:0] raddr_b;
  rec_t          rdata_b;

  logic          in_acc;
  logic          has_room;
  logic [CW-1:0] count_new;
  logic [CW:0]   lc;
  logic [CW:0]   rc;
  logic          lc_ok;
  logic          rc_ok;
  logic          pick_l;
  logic          pick_r;
  logic [KEY_W-1:0] best_key;
  logic          emit_last;

  hsk_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re_a   (re_a),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .re_b   (re_b),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  // input handshake and load bookkeeping
  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign has_room  = (fill < CW'(DEPTH));
  assign count_new = has_room ? fill + 1'b1 : fill;

  // children of the current node and the sift-down compare
  assign lc       = (CW + 1)'({node, 1'b1});
  assign rc       = lc + 1'b1;
  assign lc_ok    = (lc < {1'b0, size});
  assign rc_ok    = (rc < {1'b0, size});
  assign pick_l   = lc_ok && (rdata_a.key > hold.key);
  assign best_key = pick_l ? rdata_a.key : hold.key;
  assign pick_r   = rc_ok && (rdata_b.key > best_key);

  assign emit_last = ((k + 1'b1) == count);

  // ram port selection per state
  always_comb begin
    we      = 1'b0;
    waddr   = fill[AW-1:0];
    wdata   = '{key: discount_key, tag: item_tag};
    re_a    = 1'b0;
    raddr_a = node;
    re_b    = 1'b0;
    raddr_b = rc[AW-1:0];
    unique case (state)
      S_LOAD: begin
        we = in_acc && has_room;
      end
      S_BUILD_NEXT: begin
        re_a    = (j != '0);
        raddr_a = AW'(j - 1'b1);
      end
      S_SIFT_HOLD, S_SIFT_RD: begin
        re_a    = 1'b1;
        raddr_a = lc[AW-1:0];
        re_b    = 1'b1;
        raddr_b = rc[AW-1:0];
      end
      S_SIFT_CMP: begin
        we    = 1'b1;
        waddr = node;
        priority if (pick_r) begin
          wdata = rdata_b;
        end else if (pick_l) begin
          wdata = rdata_a;
        end else begin
          wdata = hold;
        end
      end
      S_EX_NEXT: begin
        re_a    = (j > CW'(1));
        raddr_a = '0;
        re_b    = (j > CW'(1));
        raddr_b = AW'(j - 1'b1);
      end
      S_EX_WR: begin
        we    = 1'b1;
        waddr = AW'(j - 1'b1);
        wdata = rdata_a;
      end
      S_EMIT_RD: begin
        re_a    = 1'b1;
        raddr_a = k[AW-1:0];
      end
      S_EMIT_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output word taken and no new word loaded behind it
      if (out_valid && !out_stall && state != S_EMIT_WAIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            fill <= count_new;
            ovf  <= ovf || !has_room;
            if (batch_end) begin
              count <= count_new;
              j     <= count_new >> 1;
              state <= S_BUILD_NEXT;
            end
          end
        end
        S_BUILD_NEXT: begin
          if (j == '0) begin
            j     <= count;
            state <= S_EX_NEXT;
          end else begin
            node        <= AW'(j - 1'b1);
            j           <= j - 1'b1;
            size        <= count;
            build_phase <= 1'b1;
            state       <= S_SIFT_HOLD;
          end
        end
        S_SIFT_HOLD: begin
          hold  <= rdata_a;
          state <= S_SIFT_CMP;
        end
        S_SIFT_RD: begin
          state <= S_SIFT_CMP;
        end
        S_SIFT_CMP: begin
          if (pick_l || pick_r) begin
            node  <= pick_r ? rc[AW-1:0] : lc[AW-1:0];
            state <= S_SIFT_RD;
          end else begin
            state <= build_phase ? S_BUILD_NEXT : S_EX_NEXT;
          end
        end
        S_EX_NEXT: begin
          if (j > CW'(1)) begin
            state <= S_EX_WR;
          end else begin
            k     <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EX_WR: begin
          hold        <= rdata_b;
          node        <= '0;
          size        <= j - 1'b1;
          j           <= j - 1'b1;
          build_phase <= 1'b0;
          state       <= S_SIFT_RD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            sorted_key <= rdata_a.key;
            sorted_tag <= rdata_a.tag;
            run_last   <= emit_last;
            overflowed <= ovf;
            if (emit_last) begin
              fill  <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // store never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  // a write never shares a cycle with a read, so no read-during-write on one entry
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(we && (re_a || re_b)))
    else $error("ram read and write in the same cycle");

  // the node under sift-down lies inside the active heap
  a_node_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIFT_CMP) |-> (CW'(node) < size))
    else $error("sift node outside heap");

  // a root-to-end swap only happens with at least two records left
  a_swap_size: assert property (@(posedge clk) disable iff (rst)
    (state == S_EX_WR) |-> (j > CW'(1)))
    else $error("swap with heap smaller than two");

  // a result word is only produced for a stored record
  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_WAIT) |-> (k < count))
    else $error("emit index beyond batch");
`endif

endmodule

/* design/hsk_ram.sv */
// hsk_ram: generic ram with one write port and two registered read ports
// no dependencies; used by heap_sort_by_key for the record store
module hsk_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held while not enabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* test/tb_top.sv */
// tb_top: self-checking bench for the heap_sort_by_key batch sorter
// depends on hsk_pkg and heap_sort_by_key; a class predicts each sorted batch
module tb_top;
  import hsk_pkg::*;

  localparam int DEPTH = 32;
  localparam int ITEMS_TARGET = 124;
  localparam int HOLD_AT = 25;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;

  // one expected output word: record plus batch flags
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             ovf;
  } sorted_word_t;

  // collects a batch, heap sorts it on batch end and checks the emitted words
  class sort_checker;
    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [TAG_W-1:0] tag_mem [DEPTH];
    int               held;
    bit               dropped;
    sorted_word_t     sorted_due [$];
    int               errors;

    function new();
      held = 0;
      dropped = 1'b0;
      errors = 0;
    endfunction

    function void swap_entries(int a, int b);
      logic [KEY_W-1:0] k;
      logic [TAG_W-1:0] t;
      k = key_mem[a];
      t = tag_mem[a];
      key_mem[a] = key_mem[b];
      tag_mem[a] = tag_mem[b];
      key_mem[b] = k;
      tag_mem[b] = t;
    endfunction

    // only a strictly greater child is promoted
    function void sift_down(int size, int node);
      int  top;
      int  lc;
      bit  done;
      done = 1'b0;
      while (!done) begin
        top = node;
        lc = 2 * node + 1;
        if (lc < size && key_mem[lc] > key_mem[top]) top = lc;
        if (lc + 1 < size && key_mem[lc+1] > key_mem[top]) top = lc + 1;
        if (top == node) begin
          done = 1'b1;
        end else begin
          swap_entries(node, top);
          node = top;
        end
      end
    endfunction

    // bottom-up build, then root-to-end swaps
    function void heap_sort_held();
      for (int j = held / 2; j > 0; j--) sift_down(held, j - 1);
      for (int j = held; j > 1; j--) begin
        swap_entries(0, j - 1);
        sift_down(j - 1, 0);
      end
    endfunction

    function void note_record(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic e);
      sorted_word_t w;
      if (held < DEPTH) begin
        key_mem[held] = k;
        tag_mem[held] = t;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (e) begin
        heap_sort_held();
        for (int i = 0; i < held; i++) begin
          w.key = key_mem[i];
          w.tag = tag_mem[i];
          w.last = (i == held - 1);
          w.ovf = dropped;
          sorted_due.push_back(w);
        end
        held = 0;
        dropped = 1'b0;
      end
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic l, logic o);
      sorted_word_t w;
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual key %0d tag %0d last %0b ovf %0b",
                 $time, k, t, l, o);
        errors++;
      end else begin
        w = sorted_due.pop_front();
        check_field("sorted_key", 32'(w.key), 32'(k));
        check_field("sorted_tag", 32'(w.tag), 32'(t));
        check_field("run_last", 32'(w.last), 32'(l));
        check_field("overflowed", 32'(w.ovf), 32'(o));
      end
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [KEY_W-1:0] discount_key;
  logic [TAG_W-1:0] item_tag;
  logic             batch_end;
  logic             out_valid;
  logic             out_stall;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             run_last;
  logic             overflowed;

  sort_checker sb;
  bit          quiet_in;
  int          items_sent;
  int          results_seen;
  int          stall_left;

  heap_sort_by_key #(.DEPTH(DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .discount_key (discount_key),
    .item_tag     (item_tag),
    .batch_end    (batch_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_key   (sorted_key),
    .sorted_tag   (sorted_tag),
    .run_last     (run_last),
    .overflowed   (overflowed)
  );

  always #2 clk = ~clk;

  // offer one word after a random gap and wait until it is taken
  task automatic send_record(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                             input logic e);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    discount_key <= k;
    item_tag <= t;
    batch_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_record(k, t, e);
    items_sent++;
  endtask

  // keys are full 14-bit, in nominal range, or crowded into a few values for ties
  task automatic send_random_batch(input int size);
    logic [KEY_W-1:0] k;
    int               pick;
    for (int i = 0; i < size; i++) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) k = KEY_W'($urandom);
      else if (pick == 1) k = KEY_W'($urandom_range(0, 10000));
      else k = KEY_W'($urandom_range(0, 7));
      send_record(k, TAG_W'($urandom), i == size - 1);
    end
  endtask

  // output side: check every word taken, stall between words, one long hold
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result(sorted_key, sorted_tag, run_last, overflowed);
        results_seen++;
        if (results_seen == HOLD_AT) stall_left = HOLD_CYCLES;
        else if ((results_seen / 25) % 3 == 1) stall_left = 0;
        else stall_left = $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // run time limit
  initial begin
    #1600000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int batch;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    discount_key = '0;
    item_tag = '0;
    batch_end = 1'b0;
    out_stall = 1'b0;
    quiet_in = 1'b0;
    items_sent = 0;
    results_seen = 0;
    stall_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // single-word batches at the field extremes, key above range included
    send_record(14'd0, 16'h0000, 1'b1);
    send_record(14'h3FFF, 16'hFFFF, 1'b1);
    // all keys equal: order comes from the heap procedure alone
    send_record(14'd5, 16'd1, 1'b0);
    send_record(14'd5, 16'd2, 1'b0);
    send_record(14'd5, 16'd3, 1'b0);
    send_record(14'd5, 16'd4, 1'b1);
    // mixed with ties at both ends of the nominal range
    send_record(14'd10000, 16'h1111, 1'b0);
    send_record(14'd0, 16'h2222, 1'b0);
    send_record(14'd10000, 16'h3333, 1'b0);
    send_record(14'd1, 16'h4444, 1'b0);
    send_record(14'd9999, 16'h5555, 1'b0);
    send_record(14'd0, 16'h6666, 1'b1);
    // descending and ascending runs
    send_record(14'd200, 16'hAAAA, 1'b0);
    send_record(14'd100, 16'h5555, 1'b1);
    for (int i = 0; i < 5; i++) send_record(14'(i * 3), 16'(i), i == 4);

    // store exactly full; the long output hold falls in this batch
    send_random_batch(DEPTH);
    // one word too many: the end marker itself is dropped
    send_random_batch(DEPTH + 1);
    batch = 0;
    while (items_sent < ITEMS_TARGET) begin
      quiet_in = (batch % 4 == 2);
      send_random_batch($urandom_range(1, 12));
      batch++;
    end
    quiet_in = 1'b0;
    in_valid <= 1'b0;
    batch_end <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/hsk_pkg.sv
design/hsk_ram.sv
design/heap_sort_by_key.sv
test/tb_top.sv
